### sv/eae_pkg.sv
// Shared types, constants and the byte code table of the escape alphabet encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package eae_pkg;

    // channel alphabet and escape letters, index 0 is the leftmost character
    localparam int ALPHA_LEN = 64;
    localparam int ESC_LEN   = 4;
    localparam logic [0:ALPHA_LEN-1][7:0] ALPHABET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIKJLMNOPQRSTUVWXYZ0123456789 _";
    localparam logic [0:ESC_LEN-1][7:0] ESC_LETTERS = "JZQX";

    localparam logic [7:0] NEWLINE = 8'd10;

    // configuration registers
    localparam int CFG_W          = 16;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 16'd76;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 16'd4096;
    localparam logic [0:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [0:0] REG_BLOCK_SIZE = 1'b1;

    // counter width default and job queue size
    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;

    // code of one byte: one character, or an escape letter and a second one
    typedef struct packed {
        logic       two;
        logic [7:0] c0;
        logic [7:0] c1;
    } t_code;

    typedef t_code [255:0] t_code_table;

    // one classified byte, handed from the front to the back
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic       two;
        logic       nl;       // newline after the code
        logic       nl_bend;  // that newline closes the block
        logic       eod_nl;   // closing newline at end of data
    } t_job;

    // built at elaboration: codes handed out in increasing byte order
    function automatic t_code_table build_code_table();
        t_code_table tbl;
        int          rank;
        int          b;
        int          i;
        logic        pass;
        rank = 0;
        for (b = 0; b < 256; b++) begin
            pass = 1'b0;
            for (i = 0; i < ALPHA_LEN; i++) begin
                if (ALPHABET[i] == b[7:0]) begin
                    pass = 1'b1;
                end
            end
            for (i = 0; i < ESC_LEN; i++) begin
                if (ESC_LETTERS[i] == b[7:0]) begin
                    pass = 1'b0;
                end
            end
            if (pass) begin
                tbl[b].two = 1'b0;
                tbl[b].c0  = b[7:0];
                tbl[b].c1  = 8'd0;
            end else begin
                tbl[b].two = 1'b1;
                tbl[b].c0  = ESC_LETTERS[(rank / ALPHA_LEN) % ESC_LEN];
                tbl[b].c1  = ALPHABET[rank % ALPHA_LEN];
                rank++;
            end
        end
        return tbl;
    endfunction

    localparam t_code_table CODE_TABLE = build_code_table();

endpackage

`default_nettype wire

### sv/eae_front.sv
// Front part: accepts input words, looks up the byte code and runs the line and
// block counters, producing one job per byte. Depends on eae_pkg.
`default_nettype none

module eae_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic                      i_end_of_data,
    input  wire logic [eae_pkg::CFG_W-1:0] i_line_width,
    input  wire logic [eae_pkg::CFG_W-1:0] i_block_size,
    input  wire logic                      i_q_full,
    output logic                           o_in_stall,
    output logic                           o_push,
    output eae_pkg::t_job                  o_job
);
    import eae_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic [COUNT_BITS-1:0] r_block_cnt, n_block_cnt;
    logic [COUNT_BITS-1:0] r_line_cnt, n_line_cnt;
    t_code                 w_code;
    logic [1:0]            w_len;
    logic [COUNT_BITS-1:0] w_blk_add, w_line_add, w_blk_mid, w_line_mid;
    logic                  w_blk_hit, w_line_hit, w_eod_nl;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [1:0] inc);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS + 1)'(inc);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    // classify the byte
    assign w_code = CODE_TABLE[i_data_byte];
    assign w_len  = w_code.two ? 2'd2 : 2'd1;

    // counter update for this byte
    always_comb begin
        w_blk_add  = sat_add(r_block_cnt, w_len);
        w_line_add = sat_add(r_line_cnt, w_len);
        w_blk_hit  = CMP_W'(w_blk_add) >= CMP_W'(i_block_size);
        w_line_hit = !w_blk_hit && (CMP_W'(w_line_add) >= CMP_W'(i_line_width));
        if (w_blk_hit) begin
            w_blk_mid  = '0;
            w_line_mid = '0;
        end else if (w_line_hit) begin
            w_blk_mid  = sat_add(w_blk_add, 2'd1);
            w_line_mid = '0;
        end else begin
            w_blk_mid  = w_blk_add;
            w_line_mid = w_line_add;
        end
        w_eod_nl = i_end_of_data && (w_blk_mid != '0);
        if (w_eod_nl) begin
            n_block_cnt = '0;
            n_line_cnt  = '0;
        end else begin
            n_block_cnt = w_blk_mid;
            n_line_cnt  = w_line_mid;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // job handed to the queue
    always_comb begin
        o_job.c0      = w_code.c0;
        o_job.c1      = w_code.c1;
        o_job.two     = w_code.two;
        o_job.nl      = w_blk_hit || w_line_hit;
        o_job.nl_bend = w_blk_hit;
        o_job.eod_nl  = w_eod_nl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_cnt <= '0;
            r_line_cnt  <= '0;
        end else if (o_push) begin
            r_block_cnt <= n_block_cnt;
            r_line_cnt  <= n_line_cnt;
        end
    end

endmodule

`default_nettype wire

### sv/eae_queue.sv
// Short job queue between the front and the back of the encoder.
// Depends on eae_pkg for the job type and depth.
`default_nettype none

module eae_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire eae_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output eae_pkg::t_job      o_job
);
    import eae_pkg::*;

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_full     = r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_job      = r_slots[r_rd];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### sv/eae_back.sv
// Back part (depends on eae_pkg): walks the head job into the output
// register one character per unstalled cycle; pops it after its last one.
`default_nettype none

module eae_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire eae_pkg::t_job i_job,
    input  wire logic          i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output logic [7:0]         o_out_char,
    output logic               o_block_end,
    output logic               o_last_of_item
);
    import eae_pkg::*;

    typedef enum logic [3:0] {
        PH_C0  = 4'b0001,
        PH_C1  = 4'b0010,
        PH_NL  = 4'b0100,
        PH_EOD = 4'b1000
    } t_phase;

    t_phase     r_phase, w_next;
    logic       w_load, w_last, w_bend;
    logic [7:0] w_char;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_block_end, r_last;

    assign w_load = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_load && w_last;

    // character of the current step and the step after it
    always_comb begin
        w_char = NEWLINE;
        w_bend = 1'b0;
        w_next = PH_C0;
        w_last = 1'b1;
        unique case (r_phase)
            PH_C0: begin
                w_char = i_job.c0;
                if (i_job.two) begin
                    w_next = PH_C1;
                    w_last = 1'b0;
                end else if (i_job.nl) begin
                    w_next = PH_NL;
                    w_last = 1'b0;
                end else if (i_job.eod_nl) begin
                    w_next = PH_EOD;
                    w_last = 1'b0;
                end
            end
            PH_C1: begin
                w_char = i_job.c1;
                if (i_job.nl) begin
                    w_next = PH_NL;
                    w_last = 1'b0;
                end else if (i_job.eod_nl) begin
                    w_next = PH_EOD;
                    w_last = 1'b0;
                end
            end
            PH_NL: begin
                w_bend = i_job.nl_bend;
                if (i_job.eod_nl) begin
                    w_next = PH_EOD;
                    w_last = 1'b0;
                end
            end
            PH_EOD: begin
                w_bend = 1'b1;
            end
            default: begin
                w_next = PH_C0;
            end
        endcase
    end

    // step sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_C0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_phase     <= w_last ? PH_C0 : w_next;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_char  <= w_char;
            r_block_end <= w_bend;
            r_last      <= w_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_block_end    = r_block_end;
    assign o_last_of_item = r_last;

endmodule

`default_nettype wire

### sv/escape_alphabet_encoder_framed_top.sv
// Escape alphabet encoder with line and block framing. An input word is taken in
// every cycle while the four-entry job queue has room; the front classifies the
// byte and updates the line and block counters at once. The back sends one
// character per cycle through its output register while not stalled, so a byte
// yields 1 to 4 characters: 1 for a plain alphabet character, 2 for an escaped
// byte, plus one for each inserted newline. Sustained throughput is set by the
// one-character output register. No clearing pass after reset. Configuration
// registers: line_width at byte address 0, block_size at 4 (low 16 bits of the
// data); depends on eae_pkg, eae_front, eae_queue and eae_back.
`default_nettype none

module escape_alphabet_encoder_framed_top #(
    parameter int COUNT_BITS = eae_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [eae_pkg::PADDR_W-1:0] paddr,
    input  wire logic [eae_pkg::PDATA_W-1:0] pwdata,
    output logic      [eae_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_end_of_data,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_out_char,
    output logic                             o_block_end,
    output logic                             o_last_of_item
);
    import eae_pkg::*;

    logic [CFG_W-1:0] r_line_width, r_block_size;
    logic             w_cfg_wr;
    logic             w_push, w_pop, w_full, w_nonempty;
    t_job             w_front_job, w_head_job;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_block_size <= BLOCK_SIZE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_LINE_WIDTH: r_line_width <= pwdata[CFG_W-1:0];
                REG_BLOCK_SIZE: r_block_size <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_LINE_WIDTH: prdata = PDATA_W'(r_line_width);
            REG_BLOCK_SIZE: prdata = PDATA_W'(r_block_size);
            default:        prdata = '0;
        endcase
    end

    eae_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_line_width  (r_line_width),
        .i_block_size  (r_block_size),
        .i_q_full      (w_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    eae_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_front_job),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_job      (w_head_job)
    );

    eae_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_nonempty),
        .i_job          (w_head_job),
        .i_out_stall    (i_out_stall),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_block_end    (o_block_end),
        .o_last_of_item (o_last_of_item)
    );

    // a block always closes on a newline
    a_bend_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_end) |-> (o_out_char == NEWLINE))
        else $error("block end on a character other than newline");

    // a full queue means the back has a word waiting
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("queue full while the output register is empty");

    // reset empties the output
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

endmodule

`default_nettype wire
